// File: design/sstod_pkg.sv
// Shared types and constants for the serial-set time-of-day clock.
// No dependencies; sstod_apb_regs, sstod_tick and the core import this package.
package sstod_pkg;

	// Item kinds on the input channel
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Register indexes on the configuration port
	localparam logic REG_TIME_START = 1'b0;
	localparam logic REG_MSG_START  = 1'b1;

	localparam logic [7:0]  TIME_START_RESET = 8'd37;  // '%'
	localparam logic [7:0]  MSG_START_RESET  = 8'd47;  // '/'
	localparam logic [7:0]  CHAR_ZERO        = 8'h30;  // '0'
	localparam logic [7:0]  CHAR_NINE        = 8'h39;  // '9'
	localparam logic [63:0] TIME_TEXT_RESET  = 64'h3030_3A30_303A_3030; // "00:00:00"

	localparam int unsigned TIME_CHARS = 8;
	localparam int unsigned MSG_SLOTS  = 16;

	// Start bytes held by the register block
	typedef struct packed {
		logic [7:0] time_start;
		logic [7:0] msg_start;
	} cfg_t;

	// Outcome of one second's advance of the time text
	typedef struct packed {
		logic        ok;
		logic [63:0] next_text;
	} tick_t;

endpackage

// File: design/sstod_in_if.sv
// Input channel: serial byte or one-second tick, valid/ready handshake.
// No dependencies.
interface sstod_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: design/sstod_out_if.sv
// Result channel: time text, message and status, valid/ready handshake.
// No dependencies.
interface sstod_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] time_text;
	logic [63:0] message_low;
	logic [63:0] message_high;
	logic [4:0]  message_count;
	logic        running;
	logic        time_invalid;
	logic        display_clear;

	modport source (
		output valid, output time_text, output message_low, output message_high,
		output message_count, output running, output time_invalid, output display_clear,
		input ready
	);
	modport sink (
		input valid, input time_text, input message_low, input message_high,
		input message_count, input running, input time_invalid, input display_clear,
		output ready
	);
endinterface

// File: design/sstod_apb_regs.sv
// APB register block holding the time-start and message-start bytes.
// Depends on sstod_pkg.
module sstod_apb_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output sstod_pkg::cfg_t   cfg
);
	import sstod_pkg::*;

	logic [7:0] time_start_q;
	logic [7:0] msg_start_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_start_q <= TIME_START_RESET;
			msg_start_q  <= MSG_START_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TIME_START: time_start_q <= pwdata[7:0];
				REG_MSG_START:  msg_start_q  <= pwdata[7:0];
				default:        ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (reg_sel)
			REG_TIME_START: prdata = {24'd0, time_start_q};
			REG_MSG_START:  prdata = {24'd0, msg_start_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.time_start = time_start_q;
	assign cfg.msg_start  = msg_start_q;

endmodule

// File: design/sstod_tick.sv
// Checks the HH:MM:SS text and works out the text one second later.
// Depends on sstod_pkg. Pure combinational, BCD carry chain of three pairs.
module sstod_tick (
	input  logic [63:0]      time_text,
	output sstod_pkg::tick_t tick
);
	import sstod_pkg::*;

	logic [7:0] ch [TIME_CHARS];
	logic [3:0] h1, h0, m1, m0, s1, s0;
	logic [3:0] h1_n, h0_n, m1_n, m0_n, s1_n, s0_n;
	logic       digits_ok;
	logic       range_ok;
	logic       c_s0, c_s1, c_m0, c_m1;

	// Split the text into characters, character 0 in the top byte
	always_comb begin
		for (int i = 0; i < TIME_CHARS; i++) begin
			ch[i] = time_text[63 - 8*i -: 8];
		end
	end

	assign digits_ok = (ch[0] >= CHAR_ZERO) && (ch[0] <= CHAR_NINE)
		&& (ch[1] >= CHAR_ZERO) && (ch[1] <= CHAR_NINE)
		&& (ch[3] >= CHAR_ZERO) && (ch[3] <= CHAR_NINE)
		&& (ch[4] >= CHAR_ZERO) && (ch[4] <= CHAR_NINE)
		&& (ch[6] >= CHAR_ZERO) && (ch[6] <= CHAR_NINE)
		&& (ch[7] >= CHAR_ZERO) && (ch[7] <= CHAR_NINE);

	// Digits are '0'..'9' once checked, so the low nibble is the value
	assign h1 = ch[0][3:0];
	assign h0 = ch[1][3:0];
	assign m1 = ch[3][3:0];
	assign m0 = ch[4][3:0];
	assign s1 = ch[6][3:0];
	assign s0 = ch[7][3:0];

	// Hours below 24, minutes and seconds below 60
	assign range_ok = ((h1 < 4'd2) || ((h1 == 4'd2) && (h0 < 4'd4)))
		&& (m1 < 4'd6) && (s1 < 4'd6);

	// BCD increment with wraps at 60, 60 and 24
	always_comb begin
		c_s0 = (s0 == 4'd9);
		s0_n = c_s0 ? 4'd0 : s0 + 4'd1;
		c_s1 = c_s0 && (s1 == 4'd5);
		s1_n = c_s0 ? (c_s1 ? 4'd0 : s1 + 4'd1) : s1;
		c_m0 = c_s1 && (m0 == 4'd9);
		m0_n = c_s1 ? (c_m0 ? 4'd0 : m0 + 4'd1) : m0;
		c_m1 = c_m0 && (m1 == 4'd5);
		m1_n = c_m0 ? (c_m1 ? 4'd0 : m1 + 4'd1) : m1;
		h1_n = h1;
		h0_n = h0;
		if (c_m1) begin
			if ((h1 == 4'd2) && (h0 == 4'd3)) begin
				h1_n = 4'd0;
				h0_n = 4'd0;
			end else if (h0 == 4'd9) begin
				h1_n = h1 + 4'd1;
				h0_n = 4'd0;
			end else begin
				h0_n = h0 + 4'd1;
			end
		end
	end

	assign tick.ok = digits_ok && range_ok;
	// Separators pass through untouched
	assign tick.next_text = {
		CHAR_ZERO[7:4], h1_n, CHAR_ZERO[7:4], h0_n, ch[2],
		CHAR_ZERO[7:4], m1_n, CHAR_ZERO[7:4], m0_n, ch[5],
		CHAR_ZERO[7:4], s1_n, CHAR_ZERO[7:4], s0_n
	};

endmodule

// File: design/serial_set_time_of_day_clock_core.sv
// Top level of the serial-set time-of-day clock: input register, state update, result register.
// Depends on sstod_pkg, sstod_in_if, sstod_out_if, sstod_apb_regs and sstod_tick.
//
//   channel  | dir  | protocol      | payload
//   ---------+------+---------------+---------------------------------------------------
//   item     | in   | valid/ready   | action, rx_byte
//   result   | out  | valid/ready   | time_text, message_low/high, message_count, flags
//   apb      | in   | APB, no waits | time-start byte at 0x0, message-start byte at 0x4
//
// One item per cycle while the result register is free: an item is held in the input register,
// and the state update and result capture happen together on the edge where it advances.
// The input register refills whenever the result register is empty or being taken,
// so a stalled result blocks at most one further item. No clearing pass after reset:
// the block state is in flip-flops that the asynchronous reset sets at once.
module serial_set_time_of_day_clock_core #(
	parameter int unsigned MESSAGE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sstod_in_if.sink    item,
	sstod_out_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sstod_pkg::*;

	localparam logic [4:0] DEPTH = 5'(MESSAGE_DEPTH);

	cfg_t  cfg;
	tick_t tick;

	// Input register
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;

	// Block state
	logic [63:0] time_q,  time_n;
	logic [7:0]  msg_q [MSG_SLOTS];
	logic [7:0]  msg_n [MSG_SLOTS];
	logic [4:0]  msg_len_q, msg_len_n;
	logic [2:0]  tidx_q, tidx_n;
	logic [4:0]  midx_q, midx_n;
	logic        ld_time_q, ld_time_n;
	logic        ld_msg_q, ld_msg_n;
	logic        run_q, run_n;
	logic        invalid_n, clear_n;
	logic [4:0]  midx_inc;

	// Result register
	logic        out_valid_q;
	logic [63:0] out_time_q, out_low_q, out_high_q;
	logic [4:0]  out_count_q;
	logic        out_run_q, out_invalid_q, out_clear_q;

	sstod_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sstod_tick u_tick (
		.time_text (time_q),
		.tick      (tick)
	);

	// Handshake: the held item moves on when the result register is free
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1  <= item.action;
			rx_byte_s1 <= item.rx_byte;
		end
	end

	assign midx_inc = midx_q + 5'd1;

	// Next state for the held item
	always_comb begin
		time_n    = time_q;
		msg_n     = msg_q;
		msg_len_n = msg_len_q;
		tidx_n    = tidx_q;
		midx_n    = midx_q;
		ld_time_n = ld_time_q;
		ld_msg_n  = ld_msg_q;
		run_n     = run_q;
		invalid_n = 1'b0;
		clear_n   = 1'b0;
		if (action_s1 == ACT_BYTE) begin
			priority if (rx_byte_s1 == cfg.time_start) begin
				ld_time_n = 1'b1;
				ld_msg_n  = 1'b0;
				tidx_n    = 3'd0;
				run_n     = 1'b0;
			end else if (ld_time_q) begin
				for (int i = 0; i < TIME_CHARS; i++) begin
					if (tidx_q == 3'(i)) begin
						time_n[63 - 8*i -: 8] = rx_byte_s1;
					end
				end
				if (tidx_q == 3'd7) begin
					ld_time_n = 1'b0;
					tidx_n    = 3'd0;
					run_n     = 1'b1;
				end else begin
					tidx_n = tidx_q + 3'd1;
				end
			end else if (rx_byte_s1 == cfg.msg_start) begin
				ld_msg_n  = 1'b1;
				midx_n    = 5'd0;
				msg_len_n = 5'd0;
				for (int i = 0; i < MSG_SLOTS; i++) begin
					msg_n[i] = 8'd0;
				end
				clear_n = 1'b1;
				run_n   = 1'b0;
			end else if (ld_msg_q) begin
				clear_n = 1'b1;
				run_n   = 1'b1;
				if (midx_q < DEPTH) begin
					msg_n[midx_q[3:0]] = rx_byte_s1;
					midx_n    = midx_inc;
					msg_len_n = midx_inc;
					if (midx_inc >= DEPTH) begin
						ld_msg_n = 1'b0;
						midx_n   = 5'd0;
					end
				end else begin
					msg_len_n = midx_q;
					ld_msg_n  = 1'b0;
					midx_n    = 5'd0;
				end
			end
		end else if (run_q) begin
			clear_n   = 1'b1;
			invalid_n = !tick.ok;
			if (tick.ok) begin
				time_n = tick.next_text;
			end
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= TIME_TEXT_RESET;
			for (int i = 0; i < MSG_SLOTS; i++) begin
				msg_q[i] <= 8'd0;
			end
			msg_len_q <= 5'd0;
			tidx_q    <= 3'd0;
			midx_q    <= 5'd0;
			ld_time_q <= 1'b0;
			ld_msg_q  <= 1'b0;
			run_q     <= 1'b1;
		end else if (advance) begin
			time_q    <= time_n;
			msg_q     <= msg_n;
			msg_len_q <= msg_len_n;
			tidx_q    <= tidx_n;
			midx_q    <= midx_n;
			ld_time_q <= ld_time_n;
			ld_msg_q  <= ld_msg_n;
			run_q     <= run_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, packed with character 0 in the top byte
	always_ff @(posedge clk) begin
		if (advance) begin
			out_time_q <= time_n;
			for (int i = 0; i < 8; i++) begin
				out_low_q[63 - 8*i -: 8]  <= msg_n[i];
				out_high_q[63 - 8*i -: 8] <= msg_n[i + 8];
			end
			out_count_q   <= msg_len_n;
			out_run_q     <= run_n;
			out_invalid_q <= invalid_n;
			out_clear_q   <= clear_n;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.time_text     = out_time_q;
	assign result.message_low   = out_low_q;
	assign result.message_high  = out_high_q;
	assign result.message_count = out_count_q;
	assign result.running       = out_run_q;
	assign result.time_invalid  = out_invalid_q;
	assign result.display_clear = out_clear_q;

endmodule
